@@ rtl/d2p_pkg.sv @@
// ----------------------------------------------------------------------------
// d2p_pkg
// Shared constants, register codes and word types for the disparity to point
// reprojection block.
// ----------------------------------------------------------------------------
package d2p_pkg;

    // Field widths
    localparam int DISP_BITS      = 8;
    localparam int PIX_COORD_BITS = 12;
    localparam int COLOUR_BITS    = 8;
    localparam int OUT_BITS       = 48;

    // Fixed-point formats
    localparam int FRAC_IN  = 24;
    localparam int FRAC_OUT = 16;

    // Configuration registers
    localparam int CFG_REGS     = 5;
    localparam int CFG_BITS     = 40;
    localparam int CFG_IDX_BITS = 3;

    // Denominator width: 40-bit term minus 8-bit times 40-bit term stays in 48 bits
    localparam int W_BITS = 48;

    // Coordinate lanes sharing one denominator
    localparam int LANES  = 3;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    // Default coordinate width and the dividend width that goes with it
    localparam int COORD_BITS_DEF = 12;
    localparam int DIV_BITS_DEF   =
        ((COORD_BITS_DEF + FRAC_IN + 1 > CFG_BITS) ? COORD_BITS_DEF + FRAC_IN + 1 : CFG_BITS)
        + 1 + FRAC_OUT;

    // Saturation limits of an output coordinate
    localparam logic signed [OUT_BITS-1:0] COORD_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] COORD_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OFFSET_X     = 3'd0,
        REG_OFFSET_Y     = 3'd1,
        REG_FOCAL_LEN    = 3'd2,
        REG_INV_BASELINE = 3'd3,
        REG_DENOM_BIAS   = 3'd4
    } t_cfg_reg;

    // Colour of one pixel
    typedef struct packed {
        logic [COLOUR_BITS-1:0] red;
        logic [COLOUR_BITS-1:0] green;
        logic [COLOUR_BITS-1:0] blue;
    } t_colour;

    // Side information that travels alongside the divider
    typedef struct packed {
        t_colour          rgb;
        logic [LANES-1:0] neg;
        logic             wzero;
    } t_side;

endpackage

@@ rtl/d2p_cfg_if.sv @@
// ----------------------------------------------------------------------------
// d2p_cfg_if
// Register write channel: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface d2p_cfg_if
    import d2p_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/d2p_pixel_if.sv @@
// ----------------------------------------------------------------------------
// d2p_pixel_if
// Pixel stream: disparity, position and colour of one pixel per word.
// ----------------------------------------------------------------------------
interface d2p_pixel_if
    import d2p_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [DISP_BITS-1:0]      disparity;
    logic [PIX_COORD_BITS-1:0] column;
    logic [PIX_COORD_BITS-1:0] row;
    logic [COLOUR_BITS-1:0]    red_in;
    logic [COLOUR_BITS-1:0]    green_in;
    logic [COLOUR_BITS-1:0]    blue_in;

    modport source (
        output valid, output disparity, output column, output row,
        output red_in, output green_in, output blue_in, input ready
    );
    modport sink (
        input valid, input disparity, input column, input row,
        input red_in, input green_in, input blue_in, output ready
    );
endinterface

@@ rtl/d2p_point_if.sv @@
// ----------------------------------------------------------------------------
// d2p_point_if
// Point stream: three saturated coordinates, colour and a range flag per word.
// ----------------------------------------------------------------------------
interface d2p_point_if
    import d2p_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] point_x;
    logic signed [OUT_BITS-1:0] point_y;
    logic signed [OUT_BITS-1:0] point_z;
    logic [COLOUR_BITS-1:0]     red_out;
    logic [COLOUR_BITS-1:0]     green_out;
    logic [COLOUR_BITS-1:0]     blue_out;
    logic                       range_fault;

    modport source (
        output valid, output point_x, output point_y, output point_z,
        output red_out, output green_out, output blue_out, output range_fault,
        input ready
    );
    modport sink (
        input valid, input point_x, input point_y, input point_z,
        input red_out, input green_out, input blue_out, input range_fault,
        output ready
    );
endinterface

@@ rtl/d2p_div_pipe.sv @@
// ----------------------------------------------------------------------------
// d2p_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage, for
// several dividends that share one divisor.
// ----------------------------------------------------------------------------
module d2p_div_pipe
    import d2p_pkg::*;
#(
    parameter int N_BITS = DIV_BITS_DEF,
    parameter int D_BITS = W_BITS
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [N_BITS-1:0] i_dividend [LANES],
    input  logic [D_BITS-1:0] i_divisor,
    output logic [N_BITS-1:0] o_quotient [LANES]
);

    // Per-stage divisor copy, partial remainder and shifting dividend/quotient
    logic [D_BITS-1:0] r_div [N_BITS];
    logic [D_BITS-1:0] r_rem [N_BITS][LANES];
    logic [N_BITS-1:0] r_acc [N_BITS][LANES];

    logic [D_BITS-1:0] n_div [N_BITS];
    logic [D_BITS-1:0] n_rem [N_BITS][LANES];
    logic [N_BITS-1:0] n_acc [N_BITS][LANES];

    // One trial subtraction per stage and lane; the remainder stays below the
    // divisor, so the shifted remainder fits in D_BITS
    always_comb begin
        logic [D_BITS-1:0] v_div;
        logic [D_BITS-1:0] v_rem;
        logic [N_BITS-1:0] v_acc;
        logic [D_BITS-1:0] v_trial;
        logic              v_ge;
        for (int k = 0; k < N_BITS; k++) begin
            v_div    = (k == 0) ? i_divisor : r_div[k-1];
            n_div[k] = v_div;
            for (int l = 0; l < LANES; l++) begin
                v_rem       = (k == 0) ? '0 : r_rem[k-1][l];
                v_acc       = (k == 0) ? i_dividend[l] : r_acc[k-1][l];
                v_trial     = {v_rem[D_BITS-2:0], v_acc[N_BITS-1]};
                v_ge        = (v_trial >= v_div);
                n_rem[k][l] = v_ge ? (v_trial - v_div) : v_trial;
                n_acc[k][l] = {v_acc[N_BITS-2:0], v_ge};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N_BITS; k++) begin
                r_div[k] <= n_div[k];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_acc[k][l] <= n_acc[k][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quotient[l] = r_acc[N_BITS-1][l];
        end
    end

endmodule

@@ rtl/disparity_to_point_reprojection.sv @@
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// Turns a disparity pixel into a 3D point with colour, in fixed point.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one point word per clock once
// the pipeline is full. Four stages build the denominator and magnitudes, a
// restoring divider settles one quotient bit per stage, and a last register
// saturates and holds the point. Pixels with zero disparity are taken and
// dropped. A stall on the point side freezes the whole pipeline until the
// held point is taken. Registers may be written at any time but must only
// change while no pixel is in flight; the register port is always ready and
// indexes above four are ignored.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection
    import d2p_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    d2p_cfg_if.sink      i_cfg,
    d2p_pixel_if.sink    i_pix,
    d2p_point_if.source  o_pnt
);

    localparam int NUM_BITS =
        ((COORD_BITS + FRAC_IN + 1 > CFG_BITS) ? COORD_BITS + FRAC_IN + 1 : CFG_BITS) + 1;
    localparam int DIV_BITS = NUM_BITS + FRAC_OUT;
    localparam int USE_BITS = (COORD_BITS < PIX_COORD_BITS) ? COORD_BITS : PIX_COORD_BITS;

    // Configuration registers
    logic signed [CFG_BITS-1:0] r_offset_x;
    logic signed [CFG_BITS-1:0] r_offset_y;
    logic signed [CFG_BITS-1:0] r_focal_len;
    logic signed [CFG_BITS-1:0] r_inv_baseline;
    logic signed [CFG_BITS-1:0] r_denom_bias;

    logic w_en;

    // Stage A: captured pixel
    logic                  r_a_valid;
    logic [DISP_BITS-1:0]  r_a_disp;
    logic [COORD_BITS-1:0] r_a_col;
    logic [COORD_BITS-1:0] r_a_row;
    t_colour               r_a_rgb;

    // Stage B: disparity product and numerators
    logic                       r_b_valid;
    logic signed [W_BITS-1:0]   r_b_prod;
    logic signed [NUM_BITS-1:0] r_b_num [LANES];
    logic signed [NUM_BITS-1:0] n_b_num [LANES];
    t_colour                    r_b_rgb;

    // Stage C: denominator and numerator magnitudes
    logic                     r_c_valid;
    logic signed [W_BITS-1:0] r_c_w;
    logic [NUM_BITS-1:0]      r_c_mag [LANES];
    logic [LANES-1:0]         r_c_sign;
    t_colour                  r_c_rgb;

    // Stage D: divisor magnitude and quotient signs
    logic                r_d_valid;
    logic [W_BITS-1:0]   r_d_wmag;
    logic                r_d_wzero;
    logic [LANES-1:0]    r_d_neg;
    logic [NUM_BITS-1:0] r_d_mag [LANES];
    t_colour             r_d_rgb;

    // Side line alongside the divider
    logic [DIV_BITS-1:0] r_sb_valid;
    t_side               r_sb [DIV_BITS];
    t_side               w_d_side;

    // Divider ports
    logic [DIV_BITS-1:0] w_dividend [LANES];
    logic [DIV_BITS-1:0] w_quot [LANES];

    // Output register
    logic                       r_out_valid;
    logic signed [OUT_BITS-1:0] r_out_coord [LANES];
    logic                       r_out_fault;
    t_colour                    r_out_rgb;
    logic signed [OUT_BITS-1:0] n_out_coord [LANES];
    logic                       n_out_fault;

    // Write configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x     <= '0;
            r_offset_y     <= '0;
            r_focal_len    <= '0;
            r_inv_baseline <= '0;
            r_denom_bias   <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_OFFSET_X:     r_offset_x     <= i_cfg.data;
                REG_OFFSET_Y:     r_offset_y     <= i_cfg.data;
                REG_FOCAL_LEN:    r_focal_len    <= i_cfg.data;
                REG_INV_BASELINE: r_inv_baseline <= i_cfg.data;
                REG_DENOM_BIAS:   r_denom_bias   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Advance the whole pipeline unless a held point is still waiting
    assign w_en        = !r_out_valid || o_pnt.ready;
    assign i_pix.ready = w_en;

    // Valid bits; drop zero-disparity pixels on entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_sb_valid  <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= i_pix.valid && (i_pix.disparity != '0);
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_sb_valid  <= {r_sb_valid[DIV_BITS-2:0], r_d_valid};
            r_out_valid <= r_sb_valid[DIV_BITS-1];
        end
    end

    // Stage A: capture, keep only the low coordinate bits
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_disp      <= i_pix.disparity;
            r_a_col       <= COORD_BITS'(i_pix.column[USE_BITS-1:0]);
            r_a_row       <= COORD_BITS'(i_pix.row[USE_BITS-1:0]);
            r_a_rgb.red   <= i_pix.red_in;
            r_a_rgb.green <= i_pix.green_in;
            r_a_rgb.blue  <= i_pix.blue_in;
        end
    end

    // Stage B: form numerators in Q24 and the disparity term
    always_comb begin
        n_b_num[LANE_X] = NUM_BITS'($signed({1'b0, r_a_col, {FRAC_IN{1'b0}}}))
                        + NUM_BITS'(r_offset_x);
        n_b_num[LANE_Y] = NUM_BITS'($signed({1'b0, r_a_row, {FRAC_IN{1'b0}}}))
                        + NUM_BITS'(r_offset_y);
        n_b_num[LANE_Z] = NUM_BITS'(r_focal_len);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_prod <= W_BITS'($signed({1'b0, r_a_disp}) * r_inv_baseline);
            for (int l = 0; l < LANES; l++) begin
                r_b_num[l] <= n_b_num[l];
            end
            r_b_rgb <= r_a_rgb;
        end
    end

    // Stage C: denominator, numerator signs and magnitudes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_w <= W_BITS'(r_denom_bias) - r_b_prod;
            for (int l = 0; l < LANES; l++) begin
                r_c_sign[l] <= r_b_num[l][NUM_BITS-1];
                r_c_mag[l]  <= r_b_num[l][NUM_BITS-1] ? NUM_BITS'(-r_b_num[l])
                                                      : NUM_BITS'(r_b_num[l]);
            end
            r_c_rgb <= r_b_rgb;
        end
    end

    // Stage D: divisor magnitude, zero check, quotient signs
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_wmag  <= r_c_w[W_BITS-1] ? W_BITS'(-r_c_w) : W_BITS'(r_c_w);
            r_d_wzero <= (r_c_w == '0);
            r_d_neg   <= r_c_sign ^ {LANES{r_c_w[W_BITS-1]}};
            for (int l = 0; l < LANES; l++) begin
                r_d_mag[l] <= r_c_mag[l];
            end
            r_d_rgb <= r_c_rgb;
        end
    end

    // Scale the numerators by 2^16 for the output fraction
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_dividend[l] = {r_d_mag[l], {FRAC_OUT{1'b0}}};
        end
    end

    d2p_div_pipe #(
        .N_BITS (DIV_BITS),
        .D_BITS (W_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (w_dividend),
        .i_divisor  (r_d_wmag),
        .o_quotient (w_quot)
    );

    // Carry colour, signs and the zero-divisor flag alongside the divider
    assign w_d_side.rgb   = r_d_rgb;
    assign w_d_side.neg   = r_d_neg;
    assign w_d_side.wzero = r_d_wzero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= w_d_side;
            for (int k = 1; k < DIV_BITS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // Apply sign and saturate each coordinate; flag any clamp or zero divisor
    always_comb begin
        logic [DIV_BITS-1:0] v_q;
        logic                v_pos_ovf;
        logic                v_neg_ovf;
        logic                v_neg;
        logic                v_wzero;
        n_out_fault = 1'b0;
        v_wzero     = r_sb[DIV_BITS-1].wzero;
        for (int l = 0; l < LANES; l++) begin
            v_q       = w_quot[l];
            v_neg     = r_sb[DIV_BITS-1].neg[l];
            v_pos_ovf = |v_q[DIV_BITS-1:OUT_BITS-1];
            v_neg_ovf = (|v_q[DIV_BITS-1:OUT_BITS])
                      || (v_q[OUT_BITS-1] && (|v_q[OUT_BITS-2:0]));
            if (v_wzero) begin
                n_out_coord[l] = v_neg ? COORD_MIN : COORD_MAX;
                n_out_fault    = 1'b1;
            end else if (v_neg) begin
                if (v_neg_ovf) begin
                    n_out_coord[l] = COORD_MIN;
                    n_out_fault    = 1'b1;
                end else begin
                    n_out_coord[l] = -$signed(v_q[OUT_BITS-1:0]);
                end
            end else begin
                if (v_pos_ovf) begin
                    n_out_coord[l] = COORD_MAX;
                    n_out_fault    = 1'b1;
                end else begin
                    n_out_coord[l] = $signed(v_q[OUT_BITS-1:0]);
                end
            end
        end
    end

    // Output register: hold the point until it is taken
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_out_coord[l] <= n_out_coord[l];
            end
            r_out_fault <= n_out_fault;
            r_out_rgb   <= r_sb[DIV_BITS-1].rgb;
        end
    end

    assign o_pnt.valid       = r_out_valid;
    assign o_pnt.point_x     = r_out_coord[LANE_X];
    assign o_pnt.point_y     = r_out_coord[LANE_Y];
    assign o_pnt.point_z     = r_out_coord[LANE_Z];
    assign o_pnt.red_out     = r_out_rgb.red;
    assign o_pnt.green_out   = r_out_rgb.green;
    assign o_pnt.blue_out    = r_out_rgb.blue;
    assign o_pnt.range_fault = r_out_fault;

endmodule

@@ tb/tb_disparity_to_point_reprojection.sv @@
// ----------------------------------------------------------------------------
// tb_disparity_to_point_reprojection
// Self-checking bench for the disparity to point reprojection block.
// ----------------------------------------------------------------------------
// A short table of bring-up steps goes first: register writes and pixel words,
// some with the expected point typed in. Random phases follow. Each phase loads
// a fresh calibration (plausible camera values, wild values or pure extremes)
// and streams pixel words with random gaps. Kept words without a typed-in
// point go through a local reprojection model. Each point word out is checked
// field by field against the oldest expected point. The point side stalls at
// random, and once holds off long enough to back the pipeline up to the input.
// ----------------------------------------------------------------------------
module tb_disparity_to_point_reprojection;
    import d2p_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int PIPE_SETTLE     = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RAND_PHASES     = 9;
    localparam int PHASE_PIXELS    = 215;

    localparam logic [CFG_BITS-1:0] CAL_MAX = {1'b0, {(CFG_BITS-1){1'b1}}};
    localparam logic [CFG_BITS-1:0] CAL_MIN = {1'b1, {(CFG_BITS-1){1'b0}}};
    localparam logic [CFG_BITS-1:0] ONE_Q24 = 1 << FRAC_IN;
    localparam logic signed [OUT_BITS-1:0] ONE_Q16 = 1 << FRAC_OUT;
    localparam longint SAT_HI = COORD_MAX;
    localparam longint SAT_LO = COORD_MIN;

    // Indexes outside the register file, which the block must ignore
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [DISP_BITS-1:0]      disparity;
        logic [PIX_COORD_BITS-1:0] column;
        logic [PIX_COORD_BITS-1:0] row;
        t_colour                   rgb;
    } t_pixel_word;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
        t_colour                    rgb;
        logic                       fault;
    } t_point_word;

    typedef enum logic {STEP_WRITE, STEP_PIXEL} t_step_kind;

    typedef struct packed {
        t_step_kind              kind;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic [CFG_BITS-1:0]     reg_val;
        t_pixel_word             px;
        logic                    known;
        t_point_word             want;
    } t_bringup_step;

    logic i_clk;
    logic i_rst_n = 1'b0;

    d2p_cfg_if   cfg_bus ();
    d2p_pixel_if pix_bus ();
    d2p_point_if pnt_bus ();

    disparity_to_point_reprojection dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_pnt   (pnt_bus)
    );

    // Calibration as the block should hold it, and the points still owed
    logic signed [CFG_BITS-1:0] cal_reg [CFG_REGS];
    t_point_word                pending_points [$];
    t_bringup_step              bringup_steps [$];

    // Point typed in by hand for the pixel word on the bus, if any
    logic        known_on = 1'b0;
    t_point_word known_point;

    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    logic steady_flow   = 1'b0;

    int mismatches     = 0;
    int pixels_taken   = 0;
    int dropped_pixels = 0;
    int points_seen    = 0;
    int faulted_points = 0;
    int quiet_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    // Reprojection of one pixel under the current calibration
    function automatic t_point_word reproject_pixel(input t_pixel_word px);
        t_point_word pt;
        longint      disp, weight, depth_w, quot;
        longint      num [LANES];
        logic signed [OUT_BITS-1:0] coord [LANES];
        int          ln;
        disp    = px.disparity;
        weight  = cal_reg[REG_INV_BASELINE];
        depth_w = cal_reg[REG_DENOM_BIAS];
        depth_w = depth_w - disp * weight;
        num[LANE_X] = ((longint'(px.column) & ((longint'(1) <<< COORD_BITS_DEF) - 1)) <<< FRAC_IN);
        num[LANE_X] = num[LANE_X] + cal_reg[REG_OFFSET_X];
        num[LANE_Y] = ((longint'(px.row) & ((longint'(1) <<< COORD_BITS_DEF) - 1)) <<< FRAC_IN);
        num[LANE_Y] = num[LANE_Y] + cal_reg[REG_OFFSET_Y];
        num[LANE_Z] = cal_reg[REG_FOCAL_LEN];
        pt.fault = 1'b0;
        for (ln = 0; ln < LANES; ln++) begin
            if (depth_w == 0) begin
                quot     = (num[ln] >= 0) ? SAT_HI : SAT_LO;
                pt.fault = 1'b1;
            end else begin
                // Truncate toward zero, then clamp to the output range
                quot = (num[ln] <<< FRAC_OUT) / depth_w;
                if (quot > SAT_HI) begin
                    quot     = SAT_HI;
                    pt.fault = 1'b1;
                end
                if (quot < SAT_LO) begin
                    quot     = SAT_LO;
                    pt.fault = 1'b1;
                end
            end
            coord[ln] = quot[OUT_BITS-1:0];
        end
        pt.x   = coord[LANE_X];
        pt.y   = coord[LANE_Y];
        pt.z   = coord[LANE_Z];
        pt.rgb = px.rgb;
        return pt;
    endfunction

    function automatic logic [CFG_BITS-1:0] wild_cal_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return CAL_MIN;
            1: return CAL_MAX;
            2: return '0;
            3, 4, 5, 6: return CFG_BITS'(longint'($signed(raw[31:0])) >>> 2);
            default: return raw[CFG_BITS-1:0];
        endcase
    endfunction

    function automatic logic [PIX_COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic add_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        t_bringup_step step;
        step         = '0;
        step.kind    = STEP_WRITE;
        step.reg_idx = idx;
        step.reg_val = val;
        bringup_steps.insert(bringup_steps.size(), step);
    endtask

    task automatic add_pixel(
        input logic [DISP_BITS-1:0]      d,
        input logic [PIX_COORD_BITS-1:0] c,
        input logic [PIX_COORD_BITS-1:0] r,
        input logic [3*COLOUR_BITS-1:0]  rgb,
        input logic                      known = 1'b0,
        input logic signed [OUT_BITS-1:0] x = '0,
        input logic signed [OUT_BITS-1:0] y = '0,
        input logic signed [OUT_BITS-1:0] z = '0,
        input logic                      fault = 1'b0
    );
        t_bringup_step step;
        step              = '0;
        step.kind         = STEP_PIXEL;
        step.px.disparity = d;
        step.px.column    = c;
        step.px.row       = r;
        step.px.rgb       = rgb;
        step.known        = known;
        step.want.x       = x;
        step.want.y       = y;
        step.want.z       = z;
        step.want.rgb     = rgb;
        step.want.fault   = fault;
        bringup_steps.insert(bringup_steps.size(), step);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Offer one pixel word after a random gap and hold it until taken
    task automatic send_pixel(input t_pixel_word px, input logic known, input t_point_word want);
        int gap;
        int roll;
        roll = $urandom_range(0, 9);
        if (steady_flow || roll < 6)
            gap = 0;
        else if (roll < 8)
            gap = $urandom_range(1, 3);
        else if (roll == 8)
            gap = $urandom_range(4, 10);
        else
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 2);
        if (gap > 0) begin
            @(negedge i_clk);
            pix_bus.valid <= 1'b0;
            known_on      <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix_bus.valid     <= 1'b1;
        pix_bus.disparity <= px.disparity;
        pix_bus.column    <= px.column;
        pix_bus.row       <= px.row;
        pix_bus.red_in    <= px.rgb.red;
        pix_bus.green_in  <= px.rgb.green;
        pix_bus.blue_in   <= px.rgb.blue;
        known_on          <= known;
        known_point       <= want;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every owed point, then let dropped words drain
    task automatic settle_pipeline();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        known_on      <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic flag_field(input string name, input logic [OUT_BITS-1:0] want_v,
                              input logic [OUT_BITS-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: point %0d field %s expected %h actual %h",
                     $time, points_seen, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Track register writes, predict on pixel words, check point words
    always @(posedge i_clk) begin : point_check
        t_point_word want;
        t_point_word got;
        if (!i_rst_n) begin
            cal_reg = '{default: '0};
        end else begin
            if (cfg_bus.valid && cfg_bus.ready && cfg_bus.index < CFG_REGS)
                cal_reg[cfg_bus.index] = cfg_bus.data;
            if (pix_bus.valid && pix_bus.ready) begin
                pixels_taken++;
                if (pix_bus.disparity == '0) begin
                    dropped_pixels++;
                end else if (known_on) begin
                    pending_points.insert(pending_points.size(), known_point);
                end else begin
                    pending_points.insert(pending_points.size(), reproject_pixel(
                        {pix_bus.disparity, pix_bus.column, pix_bus.row,
                         pix_bus.red_in, pix_bus.green_in, pix_bus.blue_in}));
                end
            end
            if (pnt_bus.valid && pnt_bus.ready) begin
                got = {pnt_bus.point_x, pnt_bus.point_y, pnt_bus.point_z,
                       pnt_bus.red_out, pnt_bus.green_out, pnt_bus.blue_out,
                       pnt_bus.range_fault};
                if (pending_points.size() == 0) begin
                    $display("%0t: point word with none expected, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_points.pop_front();
                    flag_field("point_x", want.x, got.x);
                    flag_field("point_y", want.y, got.y);
                    flag_field("point_z", want.z, got.z);
                    flag_field("red_out", OUT_BITS'(want.rgb.red), OUT_BITS'(got.rgb.red));
                    flag_field("green_out", OUT_BITS'(want.rgb.green), OUT_BITS'(got.rgb.green));
                    flag_field("blue_out", OUT_BITS'(want.rgb.blue), OUT_BITS'(got.rgb.blue));
                    flag_field("range_fault", OUT_BITS'(want.fault), OUT_BITS'(got.fault));
                end
                points_seen++;
                if (got.fault)
                    faulted_points++;
            end
        end
    end

    // Point side: random stalls, one long hold-off on request
    initial begin : point_sink
        int stall_left;
        int roll;
        stall_left    = 0;
        pnt_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pnt_bus.ready <= 1'b0;
                stall_left--;
            end else if (hold_off_req && !hold_off_done) begin
                pnt_bus.ready <= 1'b0;
                stall_left    = HOLD_OFF_CYCLES - 1;
                hold_off_done = 1'b1;
            end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
                pnt_bus.ready <= 1'b0;
                roll = $urandom_range(0, 19);
                if (roll < 14)
                    stall_left = $urandom_range(0, 2);
                else if (roll < 19)
                    stall_left = $urandom_range(3, 9);
                else
                    stall_left = $urandom_range(19, 59);
            end else begin
                pnt_bus.ready <= 1'b1;
            end
        end
    end

    // Give up if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_bus.valid && pix_bus.ready) || (pnt_bus.valid && pnt_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_bringup_step step;
        t_pixel_word   px;
        logic          prev_pixel;
        logic [DISP_BITS-1:0] zero_disp;
        longint        cal_pick [CFG_REGS];
        int            phase;
        int            n;
        int            roll;

        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        pix_bus.valid     = 1'b0;
        pix_bus.disparity = '0;
        pix_bus.column    = '0;
        pix_bus.row       = '0;
        pix_bus.red_in    = '0;
        pix_bus.green_in  = '0;
        pix_bus.blue_in   = '0;
        known_point       = '0;
        prev_pixel        = 1'b0;

        // Registers at reset: zero denominator, all coordinates saturate high
        add_pixel(8'd1, 12'd0, 12'd0, 24'h000000, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        add_pixel(8'd255, 12'd4095, 12'd4095, 24'hffffff, 1'b1,
                  COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        add_pixel(8'd0, 12'd4095, 12'd4095, 24'h5a5a5a);
        // Unit denominator and depth: coordinates come straight through
        add_write(REG_FOCAL_LEN, ONE_Q24);
        add_write(REG_DENOM_BIAS, ONE_Q24);
        add_pixel(8'd1, 12'd0, 12'd0, 24'h123456, 1'b1, '0, '0, ONE_Q16, 1'b0);
        add_pixel(8'd255, 12'd4095, 12'd4095, 24'ha55ac3, 1'b1,
                  4095 << FRAC_OUT, 4095 << FRAC_OUT, ONE_Q16, 1'b0);
        add_pixel(8'd0, 12'd1, 12'd1, 24'h010203);
        // Denominator of minus the disparity: negative and truncated quotients
        add_write(REG_INV_BASELINE, ONE_Q24);
        add_write(REG_DENOM_BIAS, '0);
        add_write(REG_OFFSET_X, -(5 << (FRAC_IN - 1)));
        add_write(REG_OFFSET_Y, 1 << (FRAC_IN - 2));
        add_pixel(8'd1, 12'd1, 12'd2, 24'h102030);
        add_pixel(8'd3, 12'd1, 12'd0, 24'h405060);
        add_pixel(8'd2, 12'd4095, 12'd7, 24'h708090);
        // Denominator zero at disparity five, with numerators of both signs
        add_write(REG_DENOM_BIAS, 5 << FRAC_IN);
        add_pixel(8'd5, 12'd0, 12'd9, 24'ha0b0c0);
        add_pixel(8'd5, 12'd4095, 12'd0, 24'hd0e0f0);
        add_pixel(8'd4, 12'd3, 12'd3, 24'h0f1e2d);
        // Register extremes over a tiny denominator: overflow both ways
        add_write(REG_FOCAL_LEN, CAL_MAX);
        add_write(REG_OFFSET_X, CAL_MIN);
        add_write(REG_OFFSET_Y, CAL_MAX);
        add_write(REG_INV_BASELINE, '0);
        add_write(REG_DENOM_BIAS, 1);
        add_pixel(8'd1, 12'd0, 12'd0, 24'h3c4b5a);
        add_write(REG_FOCAL_LEN, CAL_MIN);
        add_pixel(8'd200, 12'd4095, 12'd4095, 24'h697887);
        add_write(REG_INV_BASELINE, CAL_MIN);
        add_write(REG_DENOM_BIAS, CAL_MAX);
        add_pixel(8'd255, 12'd17, 12'd4000, 24'h96a5b4);
        add_pixel(8'd1, 12'd2048, 12'd1024, 24'hc3d2e1);
        add_write(REG_INV_BASELINE, CAL_MAX);
        add_write(REG_DENOM_BIAS, CAL_MIN);
        add_pixel(8'd255, 12'd4095, 12'd0, 24'hf00f0f);
        add_pixel(8'd128, 12'd0, 12'd4095, 24'h0ff0f0);
        // Writes to indexes past the register file must change nothing
        add_write(REG_SPARE_FIRST, CAL_MAX);
        add_write(REG_SPARE_LAST, '0);
        add_pixel(8'd1, 12'd100, 12'd200, 24'h777777);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the bring-up table
        foreach (bringup_steps[i]) begin
            step = bringup_steps[i];
            if (step.kind == STEP_WRITE) begin
                if (prev_pixel)
                    settle_pipeline();
                write_reg(step.reg_idx, step.reg_val);
                prev_pixel = 1'b0;
            end else begin
                send_pixel(step.px, step.known, step.want);
                prev_pixel = 1'b1;
            end
        end

        // Random phases, each under a fresh calibration
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            settle_pipeline();
            steady_flow = (phase % 4 == 3);
            zero_disp   = DISP_BITS'($urandom_range(1, 255));
            if (phase == RAND_PHASES - 1) begin
                for (int r = 0; r < CFG_REGS; r++)
                    cal_pick[r] = $urandom_range(0, 1) ? CAL_MAX : CAL_MIN;
            end else if (phase % 3 == 2) begin
                for (int r = 0; r < CFG_REGS; r++)
                    cal_pick[r] = wild_cal_value();
            end else begin
                // Plausible camera: principal point inside the image, positive focal
                cal_pick[REG_OFFSET_X] = -((longint'($urandom_range(0, 4095)) <<< FRAC_IN)
                                           + longint'($urandom_range(0, (1 << FRAC_IN) - 1)));
                cal_pick[REG_OFFSET_Y] = -((longint'($urandom_range(0, 4095)) <<< FRAC_IN)
                                           + longint'($urandom_range(0, (1 << FRAC_IN) - 1)));
                cal_pick[REG_FOCAL_LEN] = (longint'($urandom_range(64, 4000)) <<< FRAC_IN)
                                          + longint'($urandom_range(0, (1 << FRAC_IN) - 1));
                cal_pick[REG_INV_BASELINE] = longint'($urandom_range(1 << 16, 1 << 28));
                if ($urandom_range(0, 1))
                    cal_pick[REG_INV_BASELINE] = -cal_pick[REG_INV_BASELINE];
                // Half the time place a zero denominator at one disparity
                if ($urandom_range(0, 1))
                    cal_pick[REG_DENOM_BIAS] = longint'(zero_disp) * cal_pick[REG_INV_BASELINE];
                else
                    cal_pick[REG_DENOM_BIAS] = -(longint'($urandom_range(0, 64))
                                                 * cal_pick[REG_INV_BASELINE]);
            end
            write_reg(REG_OFFSET_X, cal_pick[REG_OFFSET_X][CFG_BITS-1:0]);
            write_reg(REG_OFFSET_Y, cal_pick[REG_OFFSET_Y][CFG_BITS-1:0]);
            write_reg(REG_FOCAL_LEN, cal_pick[REG_FOCAL_LEN][CFG_BITS-1:0]);
            write_reg(REG_INV_BASELINE, cal_pick[REG_INV_BASELINE][CFG_BITS-1:0]);
            write_reg(REG_DENOM_BIAS, cal_pick[REG_DENOM_BIAS][CFG_BITS-1:0]);

            for (n = 0; n < PHASE_PIXELS; n++) begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    px.disparity = '0;
                else if (roll < 3)
                    px.disparity = zero_disp;
                else
                    px.disparity = DISP_BITS'($urandom_range(1, 255));
                px.column = pick_coord();
                px.row    = pick_coord();
                px.rgb    = 24'($urandom);
                send_pixel(px, 1'b0, '0);
                // Ask the point side for its long hold-off early in the first phase
                if (phase == 0 && n == 30)
                    hold_off_req = 1'b1;
            end
        end
        settle_pipeline();

        $display("Covered %0d pixel words (%0d dropped for zero disparity) over %0d settings.",
                 pixels_taken, dropped_pixels, RAND_PHASES + 8);
        $display("Checked %0d point words, %0d with range fault; %0d field mismatches.",
                 points_seen, faulted_points, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
